[rtl/core/phs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_pkg
// Shared types, codes and defaults of the per-class histogram statistics block.
// ----------------------------------------------------------------------------
package phs_pkg;

  localparam int CENTERS_DEF     = 16;
  localparam int MAX_VECTORS_DEF = 256;
  localparam int MAX_CLASSES_DEF = 16;

  localparam int CMD_W  = 2;
  localparam int LBL_W  = 16;
  localparam int BIDX_W = 4;
  localparam int VAL_W  = 16;
  localparam int SIDX_W = 4;
  localparam int VAR_W  = 32;
  localparam int MCNT_W = 9;
  localparam int CF_W   = 5;
  localparam int STS_W  = 2;
  localparam int NC_W   = 5;

  localparam logic [NC_W-1:0] NC_RESET = 5'd16;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_FINISH = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STS_W-1:0] {
    ST_OK           = 2'd0,
    ST_CLASS_FULL   = 2'd1,
    ST_STORE_FULL   = 2'd2,
    ST_NOT_COMPUTED = 2'd3
  } status_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [LBL_W-1:0]  label;
    logic [BIDX_W-1:0] bin_index;
    logic [VAL_W-1:0]  value;
    logic [SIDX_W-1:0] class_slot;
  } in_item_t;

  typedef struct packed {
    logic [LBL_W-1:0]  class_label;
    logic [VAL_W-1:0]  mean_value;
    logic [VAR_W-1:0]  variance_value;
    logic [MCNT_W-1:0] member_count;
    logic [CF_W-1:0]   classes_found;
    logic [STS_W-1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_QRY,
    S_RESULT,
    S_CSTART,
    S_BIN,
    S_PASS,
    S_DRAIN,
    S_DIV,
    S_NEXT
  } fsm_state_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_do;
    logic cmp_init;
    logic acc_clr;
    logic issue;
    logic pass_set;
    logic pass_clr;
    logic div_start;
    logic mean_latch;
    logic st_wr;
    logic st_zero;
    logic bin_step;
    logic set_computed;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic cc_zero;
    logic bin_ge_n;
    logic last_vec;
    logic pipe_busy;
    logic div_done;
    logic pass;
    logic last_bin;
    logic last_cls;
    logic out_free;
  } ctrl_sts_t;

endpackage
`default_nettype wire

[rtl/core/phs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface phs_in_if import phs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface phs_out_if import phs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/per_class_histogram_statistics.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// per_class_histogram_statistics
// Per-class bin mean and two-pass variance over labelled histogram vectors.
// ----------------------------------------------------------------------------
// Load: a bin transaction is accepted, then S_LOAD does the store write and
//   class lookup. Query: S_QRY waits on the registered store read, then
//   S_RESULT loads the result register once it is free. NOP: dropped at accept.
// Finish: a serial walk over the sample store and the bit-serial divider
//   (SQ_W = 41 bits wide by default), both used twice per class and bin
//   below the effective bin count; higher bins get zero results.
// Reset: synchronous, active low; counters, flags, class counts cleared, no
//   memory clearing pass. num_centers resets to 16.
module per_class_histogram_statistics import phs_pkg::*; #(
  parameter int CENTERS     = CENTERS_DEF,
  parameter int MAX_VECTORS = MAX_VECTORS_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  phs_in_if.sink               in_ch,
  phs_out_if.source            out_ch,
  input  wire logic            cfg_we,
  input  wire logic [NC_W-1:0] cfg_wdata
);

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;
  logic      in_ready;
  logic      in_fire;

  // one input transaction at a time; the result register lets loads keep
  // flowing while a query or finish result waits on the sink
  assign in_fire     = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  phs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_cmd   (cmd_t'(in_ch.data.cmd)),
    .sts      (ctrl_sts),
    .cmd      (ctrl_cmd),
    .in_ready (in_ready)
  );

  // stores, lookup, accumulate pipeline, divider and result register
  phs_datapath #(
    .CENTERS     (CENTERS),
    .MAX_VECTORS (MAX_VECTORS),
    .MAX_CLASSES (MAX_CLASSES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_ch.data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (ctrl_cmd),
    .sts       (ctrl_sts),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_data  (out_ch.data)
  );

  // each transaction is worked on alone; a NOP is dropped at once
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && (in_ch.data.cmd != CMD_NOP) |=> !in_ch.ready)
    else $error("input accepted while busy");

  // a new result only appears while no input is being taken
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised from idle");

  // stale statistics are never shown
  a_not_computed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.data.status == ST_NOT_COMPUTED) |->
      (out_ch.data.mean_value == '0) && (out_ch.data.variance_value == '0))
    else $error("statistics shown while not computed");

endmodule
`default_nettype wire

[rtl/core/phs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module phs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/phs_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module phs_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign shifted = {rem_r, q_r[DVD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

[rtl/core/phs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_datapath
// Stores, class table, accumulate pipeline, divider and result register.
// ----------------------------------------------------------------------------
module phs_datapath import phs_pkg::*; #(
  parameter int CENTERS     = CENTERS_DEF,
  parameter int MAX_VECTORS = MAX_VECTORS_DEF,
  parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire in_item_t        in_data,
  input  wire logic            cfg_we,
  input  wire logic [NC_W-1:0] cfg_wdata,
  input  wire ctrl_cmd_t       cmd,
  output ctrl_sts_t            sts,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output out_item_t            out_data
);

  localparam int CNT_W    = $clog2(MAX_VECTORS + 1);
  localparam int CC_W     = $clog2(MAX_CLASSES + 1);
  localparam int SLOT_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int VI_W     = $clog2(MAX_VECTORS);
  localparam int BIN_W    = (CENTERS > 1) ? $clog2(CENTERS) : 1;
  localparam int SA_DEPTH = MAX_VECTORS * CENTERS;
  localparam int SA_W     = $clog2(SA_DEPTH);
  localparam int ST_DEPTH = MAX_CLASSES * CENTERS;
  localparam int ST_W     = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int SQ_W     = 2 * VAL_W + CNT_W;
  localparam int NMAX     = (CENTERS < 16) ? CENTERS : 16;

  in_item_t          in_r;
  logic [NC_W-1:0]   nc_r;
  logic [CNT_W-1:0]  vc_r;
  logic [CC_W-1:0]   cc_r;
  logic [1:0]        err_r;
  logic              computed_r;
  logic [LBL_W-1:0]  lbl_r [MAX_CLASSES];
  logic [CNT_W-1:0]  cnt_r [MAX_CLASSES];

  logic [SLOT_W-1:0] c_r;
  logic [BIN_W-1:0]  b_r;
  logic [CNT_W-1:0]  v_r;
  logic              pass_r;
  logic              p1_r;
  logic              p2_r;
  logic [2*VAL_W-1:0] term_r;
  logic [SQ_W-1:0]   acc_r;
  logic [VAL_W-1:0]  mean_r;
  logic              out_valid_r;
  out_item_t         out_r;

  logic [NC_W-1:0]   n_eff;
  logic              bin_ok;
  logic              closing;
  logic              room;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [SLOT_W-1:0] new_idx;
  logic [SLOT_W-1:0] qslot;
  logic [SLOT_W-1:0] cnt_idx;
  logic [CNT_W-1:0]  cnt_rd;
  logic              add_new;
  logic              add_old;
  logic [VAL_W-1:0]  smp_rd;
  logic [SLOT_W-1:0] cls_rd;
  logic [VAL_W-1:0]  dev;
  logic [VAL_W-1:0]  mean_rd;
  logic [VAR_W-1:0]  var_rd;
  logic              div_done;
  logic [SQ_W-1:0]   quot;
  logic [1:0]        err_st;
  logic              slot_ok;
  logic              out_free;

  // effective bin count: num_centers clamped to 1..min(CENTERS,16)
  always_comb begin
    if (nc_r == '0) begin
      n_eff = NC_W'(1);
    end else if (32'(nc_r) > NMAX) begin
      n_eff = NC_W'(NMAX);
    end else begin
      n_eff = nc_r;
    end
  end

  assign bin_ok  = {1'b0, in_r.bin_index} < n_eff;
  assign closing = {1'b0, in_r.bin_index} == (n_eff - NC_W'(1));
  assign room    = 32'(vc_r) < MAX_VECTORS;
  assign new_idx = SLOT_W'(cc_r);
  assign qslot   = SLOT_W'(in_r.class_slot);

  // label lookup over the live part of the class table
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < MAX_CLASSES; i++) begin
      if (!hit && (i < 32'(cc_r)) && (lbl_r[i] == in_r.label)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign add_old = cmd.ld_do && closing && room && hit;
  assign add_new = cmd.ld_do && closing && room && !hit && (32'(cc_r) < MAX_CLASSES);

  // single read port on the member counts
  always_comb begin
    case (cmd_t'(in_r.cmd))
      CMD_LOAD:   cnt_idx = hit_idx;
      CMD_FINISH: cnt_idx = c_r;
      default:    cnt_idx = qslot;
    endcase
  end
  assign cnt_rd = cnt_r[cnt_idx];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r       <= NC_RESET;
      vc_r       <= '0;
      cc_r       <= '0;
      err_r      <= '0;
      computed_r <= 1'b0;
      for (int i = 0; i < MAX_CLASSES; i++) begin
        cnt_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        nc_r <= cfg_wdata;
      end
      if (cmd.ld_do) begin
        computed_r <= 1'b0;
        if (closing) begin
          if (!room) begin
            err_r[1] <= 1'b1;
          end else if (!hit && !(32'(cc_r) < MAX_CLASSES)) begin
            err_r[0] <= 1'b1;
          end
        end
      end
      if (add_old) begin
        cnt_r[hit_idx] <= cnt_rd + 1'b1;
        vc_r           <= vc_r + 1'b1;
      end
      if (add_new) begin
        cnt_r[new_idx] <= CNT_W'(1);
        cc_r           <= cc_r + 1'b1;
        vc_r           <= vc_r + 1'b1;
      end
      if (cmd.set_computed) begin
        computed_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (add_new) begin
      lbl_r[new_idx] <= in_r.label;
    end
  end

  // sample store and per-vector class slot
  phs_ram #(.WIDTH(VAL_W), .DEPTH(SA_DEPTH)) u_smp (
    .clk   (clk),
    .we    (cmd.ld_do && bin_ok && room),
    .waddr (SA_W'(32'(vc_r) * CENTERS + 32'(in_r.bin_index))),
    .wdata (in_r.value),
    .raddr (SA_W'(32'(v_r) * CENTERS + 32'(b_r))),
    .rdata (smp_rd)
  );

  phs_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_VECTORS)) u_vcs (
    .clk   (clk),
    .we    (add_old || add_new),
    .waddr (vc_r[VI_W-1:0]),
    .wdata (hit ? hit_idx : new_idx),
    .raddr (v_r[VI_W-1:0]),
    .rdata (cls_rd)
  );

  // result stores
  phs_ram #(.WIDTH(VAL_W), .DEPTH(ST_DEPTH)) u_mean (
    .clk   (clk),
    .we    (cmd.st_wr),
    .waddr (ST_W'(32'(c_r) * CENTERS + 32'(b_r))),
    .wdata (cmd.st_zero ? '0 : mean_r),
    .raddr (ST_W'(32'(in_r.class_slot) * CENTERS + 32'(in_r.bin_index))),
    .rdata (mean_rd)
  );

  phs_ram #(.WIDTH(VAR_W), .DEPTH(ST_DEPTH)) u_var (
    .clk   (clk),
    .we    (cmd.st_wr),
    .waddr (ST_W'(32'(c_r) * CENTERS + 32'(b_r))),
    .wdata (cmd.st_zero ? '0 : quot[VAR_W-1:0]),
    .raddr (ST_W'(32'(in_r.class_slot) * CENTERS + 32'(in_r.bin_index))),
    .rdata (var_rd)
  );

  // class / bin / vector walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r    <= '0;
      b_r    <= '0;
      v_r    <= '0;
      pass_r <= 1'b0;
    end else begin
      if (cmd.cmp_init) begin
        c_r <= '0;
        b_r <= '0;
      end else if (cmd.bin_step) begin
        if (32'(b_r) == CENTERS - 1) begin
          b_r <= '0;
          c_r <= c_r + 1'b1;
        end else begin
          b_r <= b_r + 1'b1;
        end
      end
      if (cmd.acc_clr) begin
        v_r <= '0;
      end else if (cmd.issue) begin
        v_r <= v_r + 1'b1;
      end
      if (cmd.pass_set) begin
        pass_r <= 1'b1;
      end else if (cmd.pass_clr) begin
        pass_r <= 1'b0;
      end
    end
  end

  // read -> term -> accumulate
  assign dev = (smp_rd >= mean_r) ? (smp_rd - mean_r) : (mean_r - smp_rd);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r <= 1'b0;
      p2_r <= 1'b0;
    end else begin
      p1_r <= cmd.issue;
      p2_r <= p1_r && (cls_rd == c_r);
    end
  end

  always_ff @(posedge clk) begin
    term_r <= pass_r ? (dev * dev) : {{VAL_W{1'b0}}, smp_rd};
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (p2_r) begin
      acc_r <= acc_r + SQ_W'(term_r);
    end
    if (cmd.mean_latch) begin
      mean_r <= quot[VAL_W-1:0];
    end
  end

  phs_div #(.DVD_W(SQ_W), .DVS_W(CNT_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (acc_r),
    .divisor  (cnt_rd),
    .done     (div_done),
    .quotient (quot)
  );

  // result register
  assign err_st   = err_r[0] ? ST_CLASS_FULL : (err_r[1] ? ST_STORE_FULL : ST_OK);
  assign slot_ok  = (32'(in_r.class_slot) < 32'(cc_r)) && (32'(in_r.class_slot) < MAX_CLASSES);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.classes_found  <= CF_W'(cc_r);
      out_r.class_label    <= '0;
      out_r.member_count   <= '0;
      out_r.mean_value     <= '0;
      out_r.variance_value <= '0;
      out_r.status         <= err_st;
      if (cmd_t'(in_r.cmd) == CMD_QUERY) begin
        if (!computed_r) begin
          out_r.status <= ST_NOT_COMPUTED;
        end
        if (slot_ok) begin
          out_r.class_label  <= lbl_r[qslot];
          out_r.member_count <= MCNT_W'(cnt_rd);
          if (computed_r && (32'(in_r.bin_index) < CENTERS)) begin
            out_r.mean_value     <= mean_rd;
            out_r.variance_value <= var_rd;
          end
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sts.cmd       = cmd_t'(in_r.cmd);
    sts.cc_zero   = (cc_r == '0);
    sts.bin_ge_n  = 32'(b_r) >= 32'(n_eff);
    sts.last_vec  = (v_r + 1'b1) == vc_r;
    sts.pipe_busy = p1_r || p2_r;
    sts.div_done  = div_done;
    sts.pass      = pass_r;
    sts.last_bin  = 32'(b_r) == CENTERS - 1;
    sts.last_cls  = (32'(c_r) + 1) == 32'(cc_r);
    sts.out_free  = out_free;
  end

endmodule
`default_nettype wire

[rtl/core/phs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phs_ctrl
// Sequencer for load, query and the two-pass finish computation.
// ----------------------------------------------------------------------------
module phs_ctrl import phs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_fire,
  input  wire cmd_t      in_cmd,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd,
  output logic           in_ready
);

  fsm_state_t state_r;
  fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          unique case (in_cmd)
            CMD_LOAD:   state_nxt = S_LOAD;
            CMD_FINISH: state_nxt = S_CSTART;
            CMD_QUERY:  state_nxt = S_QRY;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_LOAD: begin
        cmd.ld_do = 1'b1;
        state_nxt = S_IDLE;
      end
      S_QRY: begin
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_CSTART: begin
        cmd.cmp_init = 1'b1;
        if (sts.cc_zero) begin
          cmd.set_computed = 1'b1;
          state_nxt        = S_RESULT;
        end else begin
          state_nxt = S_BIN;
        end
      end
      S_BIN: begin
        if (sts.bin_ge_n) begin
          cmd.st_wr   = 1'b1;
          cmd.st_zero = 1'b1;
          state_nxt   = S_NEXT;
        end else begin
          cmd.acc_clr  = 1'b1;
          cmd.pass_clr = 1'b1;
          state_nxt    = S_PASS;
        end
      end
      S_PASS: begin
        cmd.issue = 1'b1;
        if (sts.last_vec) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (!sts.pass) begin
            cmd.mean_latch = 1'b1;
            cmd.pass_set   = 1'b1;
            cmd.acc_clr    = 1'b1;
            state_nxt      = S_PASS;
          end else begin
            cmd.st_wr = 1'b1;
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (sts.last_bin && sts.last_cls) begin
          cmd.set_computed = 1'b1;
          state_nxt        = S_RESULT;
        end else begin
          cmd.bin_step = 1'b1;
          state_nxt    = S_BIN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
